// ===== sv/sdrw_pkg.sv =====
// ============================================================================
// sdrw_pkg: shared types and constants for the SD SPI block read sequencer
// Item layouts, sequencer phases, command byte builder.
// ============================================================================
package sdrw_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned CMD_BYTES   = 6;

    localparam logic [7:0] CMD17_BYTE   = 8'h51;
    localparam logic [7:0] START_TOKEN  = 8'hFE;
    localparam logic [7:0] R1_READY     = 8'h00;
    localparam logic [7:0] FILL_BYTE    = 8'hFF;
    localparam logic [7:0] POLL_RESET   = 8'd10;

    localparam logic [9:0] BLOCK_CNT    = 10'(BLOCK_BYTES);
    localparam logic [9:0] BLOCK_END    = 10'(BLOCK_BYTES + 2);
    localparam logic [9:0] CMD_CNT      = 10'(CMD_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_POLL_R,
        PH_POLL_T,
        PH_DATA
    } phase_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_BYTE  = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic        req_type;
        logic [22:0] sector;
        logic [8:0]  offset;
        logic [9:0]  length;
        logic [7:0]  rx_byte;
    } req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic [8:0] data_index;
        logic       data_last;
        logic       done_res;
    } res_t;

    function automatic logic [7:0] cmd_byte(input logic [2:0] k, input logic [22:0] sector);
        logic [7:0] b;
        case (k)
            3'd0:    b = CMD17_BYTE;
            3'd1:    b = sector[22:15];
            3'd2:    b = sector[14:7];
            3'd3:    b = {sector[6:0], 1'b0};
            3'd4:    b = 8'h00;
            default: b = FILL_BYTE;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/sdrw_chan_if.sv =====
// ============================================================================
// sdrw_chan_if: valid/ready channel
// Carries one item of type T from source to sink.
// ============================================================================
interface sdrw_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sdrw_seq.sv =====
// ============================================================================
// sdrw_seq: read sequencer state and per-item step logic
// Computes the result of one item and updates phase and counters on fire.
// ============================================================================
module sdrw_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  sdrw_pkg::req_t  item,
    input  logic [7:0]      poll_limit,
    output sdrw_pkg::res_t  res
);
    import sdrw_pkg::*;

    phase_t      phase_reg,       phase_next;
    logic [9:0]  byte_count_reg,  byte_count_next;
    logic [7:0]  poll_count_reg,  poll_count_next;
    logic [22:0] held_sector_reg, held_sector_next;
    logic [8:0]  held_offset_reg, held_offset_next;
    logic [9:0]  held_length_reg, held_length_next;

    logic [9:0]  room;
    logic [10:0] win_end;
    logic [9:0]  bc_inc;
    logic [7:0]  pc_inc;
    logic [7:0]  want;
    logic [9:0]  rel;

    assign room    = BLOCK_CNT - {1'b0, item.offset};
    assign win_end = {2'b00, held_offset_reg} + {1'b0, held_length_reg};
    assign bc_inc  = byte_count_reg + 10'd1;
    assign pc_inc  = poll_count_reg + 8'd1;
    assign want    = (phase_reg == PH_POLL_R) ? R1_READY : START_TOKEN;
    assign rel     = byte_count_reg - {1'b0, held_offset_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        poll_count_next  = poll_count_reg;
        held_sector_next = held_sector_reg;
        held_offset_next = held_offset_reg;
        held_length_next = held_length_reg;
        res              = '0;
        if (item.req_type == REQ_START)
        begin
            held_sector_next = item.sector;
            held_offset_next = item.offset;
            held_length_next = (item.length > room) ? room : item.length;
            phase_next       = PH_CMD;
            poll_count_next  = 8'd0;
            byte_count_next  = 10'd1;
            res.tx_valid     = 1'b1;
            res.tx_byte      = CMD17_BYTE;
            res.chip_select  = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    res.tx_valid    = 1'b1;
                    res.chip_select = 1'b1;
                    if (byte_count_reg < CMD_CNT)
                    begin
                        res.tx_byte     = cmd_byte(byte_count_reg[2:0], held_sector_reg);
                        byte_count_next = bc_inc;
                    end
                    else
                    begin
                        res.tx_byte     = FILL_BYTE;
                        phase_next      = PH_POLL_R;
                        poll_count_next = 8'd0;
                    end
                end
                PH_POLL_R, PH_POLL_T:
                begin
                    res.tx_valid    = 1'b1;
                    res.tx_byte     = FILL_BYTE;
                    res.chip_select = 1'b1;
                    poll_count_next = pc_inc;
                    if (item.rx_byte == want || pc_inc >= poll_limit)
                    begin
                        poll_count_next = 8'd0;
                        if (phase_reg == PH_POLL_R)
                        begin
                            phase_next = PH_POLL_T;
                        end
                        else
                        begin
                            phase_next      = PH_DATA;
                            byte_count_next = 10'd0;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (byte_count_reg >= {1'b0, held_offset_reg}
                        && {1'b0, byte_count_reg} < win_end)
                    begin
                        res.data_valid = 1'b1;
                        res.data_byte  = item.rx_byte;
                        res.data_index = rel[8:0];
                        res.data_last  = ({1'b0, bc_inc} == win_end);
                    end
                    byte_count_next = bc_inc;
                    if (bc_inc < BLOCK_END)
                    begin
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = FILL_BYTE;
                        res.chip_select = 1'b1;
                    end
                    else
                    begin
                        phase_next      = PH_IDLE;
                        byte_count_next = 10'd0;
                        res.done_res    = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= '0;
            poll_count_reg  <= '0;
            held_sector_reg <= '0;
            held_offset_reg <= '0;
            held_length_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            poll_count_reg  <= poll_count_next;
            held_sector_reg <= held_sector_next;
            held_offset_reg <= held_offset_next;
            held_length_reg <= held_length_next;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.done_res |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.data_valid |-> phase_reg == PH_DATA)
        else $error("data captured outside data phase");

    a_cs_tx: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> res.chip_select == res.tx_valid)
        else $error("chip select disagrees with tx valid");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.data_valid |-> {1'b0, res.data_index} < held_length_reg)
        else $error("data index beyond length");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.req_type == REQ_START
        |=> {2'b00, held_offset_reg} + {1'b0, held_length_reg} <= 11'(BLOCK_BYTES))
        else $error("length not clamped");

endmodule

// ===== sv/sd_spi_block_read_window.sv =====
// ============================================================================
// sd_spi_block_read_window: SD card SPI mode single block read sequencer
// Input register, step logic, result register; poll limit register.
// ============================================================================
// A result enters the result register when its item leaves the input register.
// One item per cycle while the result channel is not stalled; the step in sdrw_seq is combinational.
// An item is taken while a finished result waits, until the input register fills.
// Reset: idle phase, counters and held fields zero, poll limit 10, both
// pipeline registers empty.
module sd_spi_block_read_window (
    input  logic         clk,
    input  logic         rst_n,
    sdrw_chan_if.sink    req,
    sdrw_chan_if.source  res,
    sdrw_chan_if.sink    cfg
);
    import sdrw_pkg::*;

    logic       in_valid_reg;
    req_t       in_item_reg;
    logic       out_valid_reg;
    res_t       out_item_reg;
    logic [7:0] poll_limit_reg;
    logic       fire;
    res_t       step_res;

    assign fire      = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || fire;
    assign cfg.ready = 1'b1;
    assign res.valid = out_valid_reg;
    assign res.data  = out_item_reg;

    sdrw_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (in_item_reg),
        .poll_limit (poll_limit_reg),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            poll_limit_reg <= POLL_RESET;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                poll_limit_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg <= req.data;
        end
        if (fire)
        begin
            out_item_reg <= step_res;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("result overwritten while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_item_reg))
        else $error("input item lost while stalled");

    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top: SD SPI single block read sequencer testbench
// Drives start and received-byte items through the request channel, tracks
// the read sequence to predict each result item, and checks every result
// field by field. Sweeps the poll limit register, stalls both channels.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

    import sdrw_pkg::*;

    class block_read_tracker;
        logic [7:0]  poll_limit;
        phase_t      phase;
        logic [9:0]  byte_count;
        logic [7:0]  poll_count;
        logic [22:0] held_sector;
        logic [8:0]  held_offset;
        logic [9:0]  held_length;
        res_t        due_results[$];
        int          errors;

        function new();
            poll_limit  = POLL_RESET;
            phase       = PH_IDLE;
            byte_count  = '0;
            poll_count  = '0;
            held_sector = '0;
            held_offset = '0;
            held_length = '0;
            errors      = 0;
        endfunction

        function logic [7:0] command_byte(int unsigned k);
            case (k)
                0:       return CMD17_BYTE;
                1:       return held_sector[22:15];
                2:       return held_sector[14:7];
                3:       return {held_sector[6:0], 1'b0};
                4:       return 8'h00;
                default: return FILL_BYTE;
            endcase
        endfunction

        function void take_req(req_t item);
            res_t        o;
            logic [7:0]  want;
            int unsigned room;
            int unsigned k;
            int unsigned stop;
            o = '0;
            if (item.req_type == REQ_START)
            begin
                room        = BLOCK_BYTES - item.offset;
                held_sector = item.sector;
                held_offset = item.offset;
                held_length = (item.length > room) ? 10'(room) : item.length;
                phase       = PH_CMD;
                poll_count  = '0;
                o.tx_valid    = 1'b1;
                o.tx_byte     = command_byte(0);
                o.chip_select = 1'b1;
                byte_count  = 10'd1;
            end
            else
            begin
                case (phase)
                    PH_CMD:
                    begin
                        o.tx_valid    = 1'b1;
                        o.chip_select = 1'b1;
                        if (byte_count < CMD_CNT)
                        begin
                            o.tx_byte  = command_byte(byte_count);
                            byte_count = byte_count + 10'd1;
                        end
                        else
                        begin
                            o.tx_byte  = FILL_BYTE;
                            phase      = PH_POLL_R;
                            poll_count = '0;
                        end
                    end
                    PH_POLL_R, PH_POLL_T:
                    begin
                        want          = (phase == PH_POLL_R) ? R1_READY : START_TOKEN;
                        o.tx_valid    = 1'b1;
                        o.tx_byte     = FILL_BYTE;
                        o.chip_select = 1'b1;
                        poll_count    = poll_count + 8'd1;
                        if (item.rx_byte == want || poll_count >= poll_limit)
                        begin
                            poll_count = '0;
                            if (phase == PH_POLL_R)
                            begin
                                phase = PH_POLL_T;
                            end
                            else
                            begin
                                phase      = PH_DATA;
                                byte_count = '0;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        k    = byte_count;
                        stop = held_offset + held_length;
                        if (k >= held_offset && k < stop)
                        begin
                            o.data_valid = 1'b1;
                            o.data_byte  = item.rx_byte;
                            o.data_index = 9'(k - held_offset);
                            o.data_last  = (k + 1 == stop);
                        end
                        byte_count = byte_count + 10'd1;
                        if (byte_count < BLOCK_END)
                        begin
                            o.tx_valid    = 1'b1;
                            o.tx_byte     = FILL_BYTE;
                            o.chip_select = 1'b1;
                        end
                        else
                        begin
                            phase      = PH_IDLE;
                            byte_count = '0;
                            o.done_res = 1'b1;
                        end
                    end
                    default: phase = PH_IDLE;
                endcase
            end
            due_results.push_back(o);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_res(res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            field_check("tx_valid", want.tx_valid, got.tx_valid);
            field_check("tx_byte", want.tx_byte, got.tx_byte);
            field_check("chip_select", want.chip_select, got.chip_select);
            field_check("data_valid", want.data_valid, got.data_valid);
            field_check("data_byte", want.data_byte, got.data_byte);
            field_check("data_index", want.data_index, got.data_index);
            field_check("data_last", want.data_last, got.data_last);
            field_check("done_res", want.done_res, got.done_res);
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sdrw_chan_if #(.T(req_t))       req_if ();
    sdrw_chan_if #(.T(res_t))       res_if ();
    sdrw_chan_if #(.T(logic [7:0])) cfg_if ();

    block_read_tracker sb = new();

    int unsigned burst_left = 0;
    int unsigned hit_pct    = 100;
    int unsigned read_items = 0;
    bit          long_hold  = 1'b0;

    sd_spi_block_read_window i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    always #5 clk = ~clk;

    function automatic req_t start_req(logic [22:0] sector, logic [8:0] offset,
                                       logic [9:0] length);
        req_t r;
        r.req_type = REQ_START;
        r.sector   = sector;
        r.offset   = offset;
        r.length   = length;
        r.rx_byte  = 8'($urandom);
        return r;
    endfunction

    function automatic req_t byte_req(logic [7:0] rx);
        req_t r;
        r.req_type = REQ_BYTE;
        r.sector   = 23'($urandom);
        r.offset   = 9'($urandom);
        r.length   = 10'($urandom);
        r.rx_byte  = rx;
        return r;
    endfunction

    task automatic send_req(input req_t item);
        if (burst_left == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge clk); while (!req_if.ready);
        sb.take_req(item);
    endtask

    // feed received bytes that follow the tracked phase until the read ends or most have been sent
    task automatic feed_bytes(input int unsigned most);
        int unsigned n;
        logic [7:0]  rx;
        n = 0;
        while (sb.phase != PH_IDLE && n < most)
        begin
            case (sb.phase)
                PH_POLL_R: rx = ($urandom_range(99) < hit_pct) ? R1_READY : 8'($urandom);
                PH_POLL_T: rx = ($urandom_range(99) < hit_pct) ? START_TOKEN : 8'($urandom);
                default:   rx = 8'($urandom);
            endcase
            send_req(byte_req(rx));
            n++;
        end
        read_items += n;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_poll_limit(input logic [7:0] value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.poll_limit = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.match_res(res_if.data);
    end

    initial
    begin : rx_side
        int unsigned mode;
        int unsigned mode_left;
        int unsigned cyc;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        res_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                res_if.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            cyc++;
            case (mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(3) != 0);
                default: res_if.ready <= (cyc % 5 != 0);
            endcase
        end
    end

    initial
    begin : stim
        logic [7:0]  limits[5];
        logic [22:0] sec;
        logic [8:0]  off;
        logic [9:0]  len;
        int unsigned p;
        int unsigned want_n;
        int unsigned left;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle bytes, clamp, restart mid-command, quick response
        send_req(byte_req(8'hFF));
        send_req(byte_req(8'h00));
        send_req(start_req(23'h7FFFFF, 9'd511, 10'h3FF));
        repeat (2) send_req(byte_req(8'h00));
        send_req(start_req('0, '0, '0));
        repeat (6) send_req(byte_req(8'hA5));
        send_req(byte_req(R1_READY));
        send_req(byte_req(START_TOKEN));
        send_req(byte_req(8'h00));
        send_req(start_req(23'h2AAAAA, '0, 10'd512));
        repeat (6) send_req(byte_req(8'h5A));
        send_req(byte_req(8'hFF));
        send_req(byte_req(R1_READY));
        send_req(byte_req(START_TOKEN));
        send_req(byte_req(8'hFF));
        hit_pct = 100;
        feed_bytes(32'hFFFF_FFFF);

        limits = '{8'd1, 8'd255, 8'd0, POLL_RESET, 8'($urandom_range(2, 254))};
        for (p = 0; p < 5; p++)
        begin
            write_poll_limit(limits[p]);
            if (p == 0)
                long_hold = 1'b1;
            read_items = 0;
            while (read_items < 120)
            begin
                if ($urandom_range(15) == 0)
                    drain();
                if (sb.phase == PH_IDLE && $urandom_range(9) == 0)
                    repeat ($urandom_range(1, 3)) send_req(byte_req(8'($urandom)));
                case ($urandom_range(3))
                    0:       sec = '0;
                    1:       sec = '1;
                    default: sec = 23'($urandom);
                endcase
                case ($urandom_range(3))
                    0:       off = '0;
                    1:       off = 9'd511;
                    default: off = 9'($urandom);
                endcase
                case ($urandom_range(4))
                    0:       len = '0;
                    1:       len = 10'd512;
                    2:       len = '1;
                    3:       len = 10'($urandom_range(1, 16));
                    default: len = 10'($urandom);
                endcase
                case ($urandom_range(3))
                    0:       hit_pct = 0;
                    1:       hit_pct = 8;
                    2:       hit_pct = 40;
                    default: hit_pct = 100;
                endcase
                send_req(start_req(sec, off, len));
                read_items++;
                case ($urandom_range(3))
                    0:       want_n = $urandom_range(1, 12);
                    1:       want_n = $urandom_range(1, 540);
                    default: want_n = 32'hFFFF_FFFF;
                endcase
                left = (read_items < 120) ? 120 - read_items : 0;
                feed_bytes((want_n < left) ? want_n : left);
            end
        end
        drain();
        repeat (5) @(posedge clk);

        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sdrw_pkg.sv
sv/sdrw_chan_if.sv
sv/sdrw_seq.sv
sv/sd_spi_block_read_window.sv
tb/tb_top.sv
